// ===== sv/spcc_pkg.sv =====
// Shared types and constants of the sprite priority and collision compositor.
// Used by the front, queue, back and top level files; depends on nothing.
package spcc_pkg;

  // Request kinds carried on the slave tuser bit.
  localparam logic CMD_COMPOSITE = 1'b0;
  localparam logic CMD_CLEAR     = 1'b1;

  // Layer classes of a frame entry and of a source pixel.
  localparam logic [1:0] LAYER_NONE = 2'd0;
  localparam logic [1:0] LAYER_BACK = 2'd1;
  localparam logic [1:0] LAYER_FORE = 2'd2;
  localparam logic [1:0] LAYER_RSVD = 2'd3;

  // Transparent source colors.
  localparam logic [7:0] COLOR_ZERO = 8'h00;
  localparam logic [7:0] COLOR_KEY  = 8'hFF;

  // Owner id meaning "no owner" (also the bitmap owner).
  localparam logic signed [4:0] OWNER_NONE = 5'sb11111;

  // Request queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Classified request as stored in the queue.
  typedef struct packed {
    logic              cmd;
    logic              in_range;
    logic [7:0]        color;
    logic [1:0]        layer;
    logic signed [4:0] sprite_id;
    logic              behind;
    logic              first;
  } spcc_item_t;

  // One frame store entry.
  typedef struct packed {
    logic [7:0]        color;
    logic [1:0]        layer;
    logic signed [4:0] owner_a;
    logic signed [4:0] owner_b;
  } spcc_entry_t;

  localparam spcc_entry_t ENTRY_RESET = '{
    color:   COLOR_ZERO,
    layer:   LAYER_NONE,
    owner_a: OWNER_NONE,
    owner_b: OWNER_NONE
  };

  // Result fields, collision_logged in bit 0.
  typedef struct packed {
    logic signed [4:0] owner_second;
    logic signed [4:0] owner_first;
    logic              pixel_written;
    logic              collision_logged;
  } spcc_result_t;

  localparam int RESULT_W   = $bits(spcc_result_t);
  localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;
  localparam int S_FIELDS_W = 35;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

  // Back status toward the top level.
  typedef struct packed {
    logic init_done;
    logic pop;
  } spcc_back_stat_t;

endpackage

// ===== sv/spcc_front.sv =====
// Front classifier: bounds check, linear address and layer fold of a request.
// Depends on spcc_pkg.
module spcc_front #(
  parameter int FRAME_WIDTH  = 366,
  parameter int FRAME_HEIGHT = 272,
  parameter int ADDR_W       = 17
) (
  input  logic                     cmd_i,
  input  logic [8:0]               dest_x_i,
  input  logic [8:0]               dest_y_i,
  input  logic [7:0]               src_color_i,
  input  logic [1:0]               src_layer_i,
  input  logic signed [4:0]        sprite_id_i,
  input  logic                     behind_background_i,
  input  logic                     first_of_blit_i,
  output spcc_pkg::spcc_item_t     item_o,
  output logic [ADDR_W-1:0]        addr_o
);

  localparam int LIN_W = ADDR_W + 11;

  logic [LIN_W-1:0] lin;

  // Row times width plus column; one small constant multiply.
  assign lin = LIN_W'(dest_y_i) * LIN_W'(FRAME_WIDTH) + LIN_W'(dest_x_i);
  assign addr_o = lin[ADDR_W-1:0];

  always_comb begin
    item_o.cmd       = cmd_i;
    item_o.in_range  = (int'(dest_x_i) < FRAME_WIDTH) && (int'(dest_y_i) < FRAME_HEIGHT);
    item_o.color     = src_color_i;
    // Fold the reserved layer code onto foreground.
    item_o.layer     = (src_layer_i == spcc_pkg::LAYER_RSVD) ? spcc_pkg::LAYER_FORE
                                                             : src_layer_i;
    item_o.sprite_id = sprite_id_i;
    item_o.behind    = behind_background_i;
    item_o.first     = first_of_blit_i;
  end

endmodule

// ===== sv/spcc_queue.sv =====
// Two-entry request queue between the front classifier and the back engine.
// Depends on spcc_pkg.
module spcc_queue #(
  parameter int ADDR_W = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  spcc_pkg::spcc_item_t push_item_i,
  input  logic [ADDR_W-1:0]    push_addr_i,
  input  logic                 pop_i,
  output spcc_pkg::spcc_item_t head_item_o,
  output logic [ADDR_W-1:0]    head_addr_o,
  output logic                 empty_o,
  output logic                 full_o
);

  spcc_pkg::spcc_item_t        item_q [spcc_pkg::QUEUE_DEPTH];
  logic [ADDR_W-1:0]           addr_q [spcc_pkg::QUEUE_DEPTH];
  logic [spcc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [spcc_pkg::QPTR_W:0]   count_q;

  assign empty_o     = (count_q == '0);
  assign full_o      = (count_q == (spcc_pkg::QPTR_W+1)'(spcc_pkg::QUEUE_DEPTH));
  assign head_item_o = item_q[rd_ptr_q];
  assign head_addr_o = addr_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q[wr_ptr_q] <= push_item_i;
      addr_q[wr_ptr_q] <= push_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/spcc_back.sv =====
// Back engine: frame store, clearing pass, read-modify-write and result register.
// Depends on spcc_pkg.
module spcc_back #(
  parameter int FRAME_WIDTH  = 366,
  parameter int FRAME_HEIGHT = 272,
  parameter int ADDR_W       = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spcc_pkg::spcc_item_t      head_item_i,
  input  logic [ADDR_W-1:0]         head_addr_i,
  input  logic                      empty_i,
  output spcc_pkg::spcc_back_stat_t stat_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output spcc_pkg::spcc_result_t    out_data_o
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD
  } state_e;

  state_e                 state_q;
  logic [ADDR_W-1:0]      clr_cnt_q;
  spcc_pkg::spcc_item_t   cur_q;
  logic [ADDR_W-1:0]      cur_addr_q;
  logic                   owner_seen_q, overlap_seen_q;
  logic                   out_valid_q;
  spcc_pkg::spcc_result_t out_data_q;

  spcc_pkg::spcc_entry_t  mem [DEPTH];
  spcc_pkg::spcc_entry_t  rdata_q;

  logic                   slot_free, pop, rd_en, mod_done;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  spcc_pkg::spcc_entry_t  mem_wdata;

  // Modify stage results.
  spcc_pkg::spcc_entry_t  upd;
  logic                   opaque, logged, written;
  logic                   own_eff, ovl_eff, own_set, ovl_set;
  logic [1:0]             dl;
  logic signed [4:0]      a, b;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop       = (state_q == S_IDLE) && !empty_i && slot_free;
  assign rd_en     = pop && head_item_i.in_range && (head_item_i.cmd == spcc_pkg::CMD_COMPOSITE);
  assign mod_done  = (state_q == S_MOD) && slot_free;

  always_comb begin
    own_eff = cur_q.first ? 1'b0 : owner_seen_q;
    ovl_eff = cur_q.first ? 1'b0 : overlap_seen_q;
    own_set = 1'b0;
    ovl_set = 1'b0;
    logged  = 1'b0;
    written = 1'b0;
    a       = rdata_q.owner_a;
    b       = rdata_q.owner_b;
    dl      = (rdata_q.layer == spcc_pkg::LAYER_NONE) ? cur_q.layer : rdata_q.layer;
    opaque  = (cur_q.color != spcc_pkg::COLOR_ZERO) && (cur_q.color != spcc_pkg::COLOR_KEY);
    upd.color = rdata_q.color;
    if (opaque) begin
      if (cur_q.layer != spcc_pkg::LAYER_NONE) begin
        if (dl == spcc_pkg::LAYER_FORE || !a[4]) begin
          if (!a[4] && b != cur_q.sprite_id) begin
            b = cur_q.sprite_id;
            if (!own_eff) begin
              logged  = 1'b1;
              own_set = 1'b1;
            end
          end else begin
            a = cur_q.sprite_id;
            if (!ovl_eff && cur_q.sprite_id != spcc_pkg::OWNER_NONE) begin
              logged  = 1'b1;
              ovl_set = 1'b1;
            end
          end
        end
        // Record the blit owner in a free owner slot.
        if (!cur_q.sprite_id[4] && a == spcc_pkg::OWNER_NONE) begin
          a = cur_q.sprite_id;
        end else if (cur_q.sprite_id != a && b == spcc_pkg::OWNER_NONE) begin
          b = cur_q.sprite_id;
        end
      end
      if (!cur_q.behind || dl == spcc_pkg::LAYER_BACK) begin
        upd.color = cur_q.color;
        dl        = cur_q.layer;
        written   = 1'b1;
      end
    end
    upd.layer   = dl;
    upd.owner_a = a;
    upd.owner_b = b;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr_q;
    mem_wdata = upd;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = spcc_pkg::ENTRY_RESET;
      end
      S_IDLE: begin
        mem_we    = pop && head_item_i.in_range && (head_item_i.cmd == spcc_pkg::CMD_CLEAR);
        mem_waddr = head_addr_i;
        mem_wdata = spcc_pkg::ENTRY_RESET;
      end
      S_MOD: begin
        mem_we = mod_done;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en)  rdata_q <= mem[head_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_cnt_q      <= '0;
      owner_seen_q   <= 1'b0;
      overlap_seen_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == ADDR_W'(DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            cur_q      <= head_item_i;
            cur_addr_q <= head_addr_i;
            if (rd_en) begin
              state_q <= S_MOD;
            end else begin
              // Clear or outside the frame: answer at once.
              if (head_item_i.first) begin
                owner_seen_q   <= 1'b0;
                overlap_seen_q <= 1'b0;
              end
              out_valid_q                 <= 1'b1;
              out_data_q.collision_logged <= 1'b0;
              out_data_q.pixel_written    <= 1'b0;
              out_data_q.owner_first      <= spcc_pkg::OWNER_NONE;
              out_data_q.owner_second     <= spcc_pkg::OWNER_NONE;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            owner_seen_q                <= own_eff | own_set;
            overlap_seen_q              <= ovl_eff | ovl_set;
            out_valid_q                 <= 1'b1;
            out_data_q.collision_logged <= logged;
            out_data_q.pixel_written    <= written;
            out_data_q.owner_first      <= upd.owner_a;
            out_data_q.owner_second     <= upd.owner_b;
            state_q                     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign stat_o.init_done = (state_q != S_CLEAR);
  assign stat_o.pop       = pop;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pop)
    else $error("request popped during clearing pass");

  a_no_pop_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> !pop)
    else $error("request popped while a pixel is in flight");

  a_written_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_done && written) |-> opaque)
    else $error("transparent pixel written");

  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !rd_en) |=> (out_valid_q && !out_data_q.collision_logged
                         && !out_data_q.pixel_written))
    else $error("clear or outside request gave a wrong result");

endmodule

// ===== sv/sprite_priority_collision_compositor_top.sv =====
// Top level of the sprite priority and collision compositor.
// Depends on spcc_pkg, spcc_front, spcc_queue and spcc_back.
//
// Usage: each slave-side request is one source pixel of a blit (tuser = 0) or
// a clear of one frame entry (tuser = 1). Each request gives exactly one
// master-side result: collision flag, write flag and both owner ids of the
// entry after the update (owners read -1 for a clear or an address outside
// the frame).
// Order: a request leaves the queue when the back engine pops it; a clear or
// outside-frame request registers its result at that pop, a composite pixel
// only after the frame store read and then the modify and write-back state.
// Throughput: a composite pixel holds the engine until its write back is
// done, set by the single-port read-then-write of the frame store; one clear
// or outside request per cycle while the result register is not held.
// Reset: a clearing pass writes every entry, FRAME_WIDTH * FRAME_HEIGHT of
// them (99552 at the defaults); s_axis_tready stays low until it ends.
// Stall: the result register holds while m_axis_tready is low; the two-entry
// queue keeps taking requests until full, then s_axis_tready drops.
module sprite_priority_collision_compositor_top #(
  parameter int FRAME_WIDTH  = 366,
  parameter int FRAME_HEIGHT = 272
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, from bit 0: dest_x[8:0], dest_y[17:9], src_color[25:18],
  // src_layer[27:26], sprite_id[32:28], behind_background[33],
  // first_of_blit[34], zero fill [39:35]
  input  logic [spcc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser, from bit 0: cmd
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, from bit 0: collision_logged[0], pixel_written[1],
  // owner_first[6:2], owner_second[11:7], zero fill [15:12]
  output logic [spcc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int ADDR_W = $clog2(FRAME_WIDTH * FRAME_HEIGHT);

  spcc_pkg::spcc_item_t      front_item, head_item;
  logic [ADDR_W-1:0]         front_addr, head_addr;
  logic                      q_empty, q_full, push;
  spcc_pkg::spcc_back_stat_t back_stat;
  spcc_pkg::spcc_result_t    result;

  // Take a request while the queue has room and the clearing pass is over.
  assign s_axis_tready = !q_full && back_stat.init_done;
  assign push          = s_axis_tvalid && s_axis_tready;

  spcc_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .cmd_i               (s_axis_tuser),
    .dest_x_i            (s_axis_tdata[8:0]),
    .dest_y_i            (s_axis_tdata[17:9]),
    .src_color_i         (s_axis_tdata[25:18]),
    .src_layer_i         (s_axis_tdata[27:26]),
    .sprite_id_i         (s_axis_tdata[32:28]),
    .behind_background_i (s_axis_tdata[33]),
    .first_of_blit_i     (s_axis_tdata[34]),
    .item_o              (front_item),
    .addr_o              (front_addr)
  );

  spcc_queue #(
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .push_addr_i (front_addr),
    .pop_i       (back_stat.pop),
    .head_item_o (head_item),
    .head_addr_o (head_addr),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  spcc_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_item_i (head_item),
    .head_addr_i (head_addr),
    .empty_i     (q_empty),
    .stat_o      (back_stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (result)
  );

  // Pad the result to whole bytes.
  assign m_axis_tdata = spcc_pkg::M_TDATA_W'(result);

endmodule

// ===== bench/sprite_priority_collision_compositor_top_tb.sv =====
// Self-checking bench for sprite_priority_collision_compositor_top: composites
// and clears are streamed in and each result is checked against a frame model.
// Depends on spcc_pkg and the compositor top level with its submodules.
module sprite_priority_collision_compositor_top_tb;

  localparam int FRAME_WIDTH  = 366;
  localparam int FRAME_HEIGHT = 272;
  localparam int FRAME_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int DIRECTED_MAX    = 25;
  localparam int RANDOM_ITEMS    = 1750;
  localparam int IDLE_PERCENT    = 18;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 20;

  // Random-phase milestones, counted in accepted requests.
  localparam int HOLD_OFF_AT = 300;
  localparam int PAUSE_AT    = 800;
  localparam int QUIET_FROM  = 1000;
  localparam int QUIET_TO    = 1400;

  // Request fields as packed on s_axis_tdata, dest_x in the lowest bits.
  typedef struct packed {
    logic              first;
    logic              behind;
    logic signed [4:0] sprite_id;
    logic [1:0]        layer;
    logic [7:0]        color;
    logic [8:0]        dest_y;
    logic [8:0]        dest_x;
  } pixel_req_t;

  // Frame model and store of pending results.
  class composite_scoreboard;
    logic [7:0]              color_mem   [FRAME_DEPTH];
    logic [1:0]              layer_mem   [FRAME_DEPTH];
    logic signed [4:0]       owner_a_mem [FRAME_DEPTH];
    logic signed [4:0]       owner_b_mem [FRAME_DEPTH];
    bit                      owner_seen;
    bit                      overlap_seen;
    spcc_pkg::spcc_result_t  expected_results[$];
    int                      mismatch_count;

    function new();
      for (int i = 0; i < FRAME_DEPTH; i++) begin
        color_mem[i]   = spcc_pkg::COLOR_ZERO;
        layer_mem[i]   = spcc_pkg::LAYER_NONE;
        owner_a_mem[i] = spcc_pkg::OWNER_NONE;
        owner_b_mem[i] = spcc_pkg::OWNER_NONE;
      end
      owner_seen     = 1'b0;
      overlap_seen   = 1'b0;
      mismatch_count = 0;
    endfunction

    // One read-modify-write of a frame entry; returns the result it gives.
    function spcc_pkg::spcc_result_t composite_pixel(logic cmd, pixel_req_t req);
      spcc_pkg::spcc_result_t res;
      int unsigned            idx;
      logic [1:0]             src_layer;
      logic [1:0]             dst_layer;
      logic signed [4:0]      id;
      logic signed [4:0]      own_a;
      logic signed [4:0]      own_b;
      res.collision_logged = 1'b0;
      res.pixel_written    = 1'b0;
      res.owner_first      = spcc_pkg::OWNER_NONE;
      res.owner_second     = spcc_pkg::OWNER_NONE;
      id        = req.sprite_id;
      src_layer = (req.layer == spcc_pkg::LAYER_RSVD) ? spcc_pkg::LAYER_FORE : req.layer;
      // The blit start drops both per-blit flags, even for clears and misses.
      if (req.first) begin
        owner_seen   = 1'b0;
        overlap_seen = 1'b0;
      end
      if (req.dest_x >= FRAME_WIDTH || req.dest_y >= FRAME_HEIGHT) return res;
      idx = req.dest_y * FRAME_WIDTH + req.dest_x;
      if (cmd == spcc_pkg::CMD_CLEAR) begin
        color_mem[idx]   = spcc_pkg::COLOR_ZERO;
        layer_mem[idx]   = spcc_pkg::LAYER_NONE;
        owner_a_mem[idx] = spcc_pkg::OWNER_NONE;
        owner_b_mem[idx] = spcc_pkg::OWNER_NONE;
        return res;
      end
      dst_layer = layer_mem[idx];
      own_a     = owner_a_mem[idx];
      own_b     = owner_b_mem[idx];
      if (dst_layer == spcc_pkg::LAYER_NONE) dst_layer = src_layer;
      if (req.color != spcc_pkg::COLOR_ZERO && req.color != spcc_pkg::COLOR_KEY) begin
        if (src_layer != spcc_pkg::LAYER_NONE) begin
          if (dst_layer == spcc_pkg::LAYER_FORE || own_a >= 0) begin
            if (own_a >= 0 && own_b != id) begin
              own_b = id;
              if (!owner_seen) begin
                res.collision_logged = 1'b1;
                owner_seen           = 1'b1;
              end
            end else begin
              own_a = id;
              if (!overlap_seen && id != spcc_pkg::OWNER_NONE) begin
                res.collision_logged = 1'b1;
                overlap_seen         = 1'b1;
              end
            end
          end
          if (id >= 0 && own_a == spcc_pkg::OWNER_NONE) begin
            own_a = id;
          end else if (id != own_a && own_b == spcc_pkg::OWNER_NONE) begin
            own_b = id;
          end
        end
        if (!req.behind || dst_layer == spcc_pkg::LAYER_BACK) begin
          color_mem[idx]    = req.color;
          dst_layer         = src_layer;
          res.pixel_written = 1'b1;
        end
      end
      layer_mem[idx]   = dst_layer;
      owner_a_mem[idx] = own_a;
      owner_b_mem[idx] = own_b;
      res.owner_first  = own_a;
      res.owner_second = own_b;
      return res;
    endfunction

    function void note_request(logic cmd, pixel_req_t req);
      expected_results = {expected_results, composite_pixel(cmd, req)};
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_result(spcc_pkg::spcc_result_t got);
      spcc_pkg::spcc_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      want = expected_results.pop_front();
      if (got.collision_logged !== want.collision_logged)
        report_mismatch($sformatf("collision_logged %b, want %b",
                                  got.collision_logged, want.collision_logged));
      if (got.pixel_written !== want.pixel_written)
        report_mismatch($sformatf("pixel_written %b, want %b",
                                  got.pixel_written, want.pixel_written));
      if (got.owner_first !== want.owner_first)
        report_mismatch($sformatf("owner_first %0d, want %0d",
                                  got.owner_first, want.owner_first));
      if (got.owner_second !== want.owner_second)
        report_mismatch($sformatf("owner_second %0d, want %0d",
                                  got.owner_second, want.owner_second));
    endtask
  endclass

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [spcc_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                             s_axis_tuser  = spcc_pkg::CMD_COMPOSITE;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [spcc_pkg::M_TDATA_W-1:0]   m_axis_tdata;

  composite_scoreboard sb = new();

  // Pacing shared by both sides; written only at rising edges by the sender.
  bit quiet_stretch = 1'b0;
  int hold_off_asked = 0;

  sprite_priority_collision_compositor_top #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hold reset low once at the start; the block then runs its clearing pass.
  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Hard stop: the clearing pass plus every request at its slowest, many times.
  initial begin
    #5_000_000;
    $display("sprite_priority_collision_compositor_top_tb NOT OK");
    $finish;
  end

  // Note every accepted request in the frame model.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_request(s_axis_tuser, pixel_req_t'(s_axis_tdata[$bits(pixel_req_t)-1:0]));
  end

  // Check every accepted result against the oldest pending one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(spcc_pkg::spcc_result_t'(m_axis_tdata[spcc_pkg::RESULT_W-1:0]));
  end

  // Receiver: stall at random, and serve a long hold-off when one is asked.
  initial begin : receiver
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_off_asked) begin
        hold_served = hold_off_asked;
        hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  function automatic pixel_req_t pixel(int x, int y, int color, logic [1:0] layer,
                                       int id, bit behind, bit first);
    pixel_req_t req;
    req.dest_x    = 9'(x);
    req.dest_y    = 9'(y);
    req.color     = 8'(color);
    req.layer     = layer;
    req.sprite_id = 5'(id);
    req.behind    = behind;
    req.first     = first;
    return req;
  endfunction

  // Offer one request after a random gap; return at the edge that takes it.
  task automatic send_request(input logic cmd, input pixel_req_t req);
    logic [spcc_pkg::S_TDATA_W-1:0] word;
    word                         = '0;
    word[$bits(pixel_req_t)-1:0] = req;
    @(negedge clk_i);
    while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  int random_sent = 0;

  // Send a random-phase request and apply the pacing milestones.
  task automatic send_random(input logic cmd, input pixel_req_t req);
    send_request(cmd, req);
    random_sent++;
    if (random_sent == HOLD_OFF_AT) hold_off_asked++;
    if (random_sent == PAUSE_AT) drain_results();
    if (random_sent == QUIET_FROM) quiet_stretch = 1'b1;
    if (random_sent == QUIET_TO) quiet_stretch = 1'b0;
  endtask

  function automatic logic [1:0] random_layer();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return spcc_pkg::LAYER_NONE;
    if (pick < 45) return spcc_pkg::LAYER_BACK;
    if (pick < 90) return spcc_pkg::LAYER_FORE;
    return spcc_pkg::LAYER_RSVD;
  endfunction

  function automatic int random_color();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return int'(spcc_pkg::COLOR_ZERO);
    if (pick < 20) return int'(spcc_pkg::COLOR_KEY);
    return $urandom_range(255);
  endfunction

  initial begin : sender
    int blit_len;
    int blit_w;
    int base_x;
    int base_y;
    int blit_id;
    logic [1:0] blit_layer;
    bit blit_behind;

    // Directed: background fill, ownership, both collision kinds, the
    // behind-background rule, transparency, reserved layer, frame edges,
    // addresses outside the frame and clears.
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(0, 0, 8'h55, spcc_pkg::LAYER_BACK, -1, 0, 1));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(0, 0, 8'h10, spcc_pkg::LAYER_FORE, 3, 1, 1));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(0, 0, 8'h20, spcc_pkg::LAYER_FORE, 5, 0, 0));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(0, 0, 8'h21, spcc_pkg::LAYER_FORE, 6, 0, 0));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(1, 0, 8'h00, spcc_pkg::LAYER_FORE, 2, 0, 1));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(1, 0, 8'hFF, spcc_pkg::LAYER_BACK, 2, 0, 0));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(1, 0, 8'h80, spcc_pkg::LAYER_FORE, 2, 0, 1));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(1, 0, 8'h81, spcc_pkg::LAYER_FORE, -1, 1, 0));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(1, 0, 8'h82, spcc_pkg::LAYER_BACK, 8, 0, 1));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(2, 0, 8'h01, spcc_pkg::LAYER_RSVD, 15, 0, 1));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(2, 0, 8'hFE, spcc_pkg::LAYER_RSVD, -16, 1, 0));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(3, 0, 8'h44, spcc_pkg::LAYER_NONE, 0, 0, 1));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(3, 0, 8'h45, spcc_pkg::LAYER_BACK, 4, 1, 0));
    send_request(spcc_pkg::CMD_COMPOSITE,
                 pixel(365, 271, 8'hAA, spcc_pkg::LAYER_FORE, 7, 0, 1));
    send_request(spcc_pkg::CMD_COMPOSITE,
                 pixel(365, 271, 8'hAB, spcc_pkg::LAYER_FORE, 1, 0, 0));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(366, 0, 8'hAC, spcc_pkg::LAYER_FORE, 1, 0, 1));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(0, 272, 8'hAD, spcc_pkg::LAYER_FORE, 1, 0, 0));
    send_request(spcc_pkg::CMD_COMPOSITE,
                 pixel(511, 511, 8'hAE, spcc_pkg::LAYER_RSVD, -1, 1, 1));
    send_request(spcc_pkg::CMD_CLEAR, pixel(0, 0, 8'h00, spcc_pkg::LAYER_NONE, -1, 0, 0));
    send_request(spcc_pkg::CMD_COMPOSITE, pixel(0, 0, 8'h30, spcc_pkg::LAYER_FORE, 2, 0, 0));
    send_request(spcc_pkg::CMD_CLEAR, pixel(365, 271, 8'hFF, spcc_pkg::LAYER_RSVD, 15, 1, 1));
    send_request(spcc_pkg::CMD_CLEAR, pixel(511, 300, 8'h12, spcc_pkg::LAYER_FORE, 3, 0, 1));
    send_request(spcc_pkg::CMD_COMPOSITE,
                 pixel(365, 271, 8'h66, spcc_pkg::LAYER_FORE, 8, 1, 0));

    // Let the directed part settle completely before the random part.
    drain_results();

    // Random: mostly blits over a small crowded window so entries are hit
    // many times, some at the frame corner, plus clears and raw noise.
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        blit_len    = $urandom_range(16, 1);
        blit_w      = $urandom_range(6, 1);
        blit_layer  = random_layer();
        blit_behind = ($urandom_range(99) < 25);
        if ($urandom_range(99) < 5) blit_id = int'($urandom_range(31));
        else blit_id = int'($urandom_range(9)) - 1;
        if ($urandom_range(99) < 10) begin
          base_x = $urandom_range(369, 360);
          base_y = $urandom_range(275, 268);
        end else begin
          base_x = $urandom_range(11);
          base_y = $urandom_range(5);
        end
        for (int k = 0; k < blit_len; k++)
          send_random(spcc_pkg::CMD_COMPOSITE,
                      pixel(base_x + k % blit_w, base_y + k / blit_w, random_color(),
                            blit_layer, blit_id, blit_behind, k == 0));
      end else if ($urandom_range(1) == 0) begin
        send_random(spcc_pkg::CMD_CLEAR,
                    pixel($urandom_range(11), $urandom_range(5), $urandom_range(255),
                          2'($urandom_range(3)), int'($urandom_range(31)),
                          1'($urandom_range(1)), 1'($urandom_range(1))));
      end else begin
        send_random(1'($urandom_range(1)),
                    pixel($urandom_range(511), $urandom_range(511), $urandom_range(255),
                          2'($urandom_range(3)), int'($urandom_range(31)),
                          1'($urandom_range(1)), 1'($urandom_range(1))));
      end
    end

    // Wait for the last results, then give stray ones a chance to show up.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.expected_results.size() == 0) begin
      $display("sprite_priority_collision_compositor_top_tb OK");
    end else begin
      $display("sprite_priority_collision_compositor_top_tb NOT OK");
    end
    $finish;
  end

endmodule
